/* hdl/sorted_key_record_table_defines.svh */
// Assertion macros shared by the checker.
`ifndef SORTED_KEY_RECORD_TABLE_DEFINES_SVH
`define SORTED_KEY_RECORD_TABLE_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define SKT_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sorted_key_record_table: check failed");

// Clocked assertion on the standard clk_i / rst_ni pair.
`define SKT_ASSERT(lbl, prop) `SKT_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* hdl/sktbl_pkg.sv */
`default_nettype none

package sktbl_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned NAME_BYTES = 8;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned NAME_W = 56;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  // Bytes a stored name keeps.
  localparam int unsigned KEEP_BYTES = (NAME_BYTES - 1 < 7) ? NAME_BYTES - 1 : 7;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_UPDATE = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_FIND   = 3'd3,
    REQ_DUMP   = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_DUP      = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
    logic [VAL_W-1:0]  value;
  } rec_t;

  // Per-cycle command broadcast to the row of cells.
  typedef struct packed {
    logic ins;
    logic del;
    logic upd;
  } cell_ctl_t;

  typedef struct packed {
    status_e           status;
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
    logic [VAL_W-1:0]  value_before;
    logic [VAL_W-1:0]  value_now;
    logic              last;
  } rsp_t;

  // Keep name bytes up to the first zero byte, at most KEEP_BYTES of them.
  function automatic logic [NAME_W-1:0] clip_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] r;
    logic              run;
    r   = '0;
    run = 1'b1;
    for (int i = 0; i < KEEP_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'h00) run = 1'b0;
      if (run) r[8*i +: 8] = raw[8*i +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/sktbl_if.sv */
`default_nettype none

interface sktbl_req_if;
  logic                            valid;
  logic                            ready;
  logic [sktbl_pkg::REQ_W-1:0]     req_type;
  logic [sktbl_pkg::KEY_W-1:0]     key;
  logic [sktbl_pkg::NAME_W-1:0]    name;
  logic [sktbl_pkg::VAL_W-1:0]     salary;

  modport source (output valid, output req_type, output key, output name, output salary,
                  input ready);
  modport sink   (input valid, input req_type, input key, input name, input salary,
                  output ready);
endinterface

interface sktbl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [sktbl_pkg::STAT_W-1:0]    status;
  logic [sktbl_pkg::KEY_W-1:0]     rec_key;
  logic [sktbl_pkg::NAME_W-1:0]    rec_name;
  logic [sktbl_pkg::VAL_W-1:0]     value_before;
  logic [sktbl_pkg::VAL_W-1:0]     value_now;
  logic                            last;

  modport source (output valid, output status, output rec_key, output rec_name,
                  output value_before, output value_now, output last, input ready);
  modport sink   (input valid, input status, input rec_key, input rec_name,
                  input value_before, input value_now, input last, output ready);
endinterface

`default_nettype wire

/* hdl/sktbl_cell.sv */
`default_nettype none

module sktbl_cell (
  input  logic                 clk_i,
  input  sktbl_pkg::cell_ctl_t ctl_i,
  input  sktbl_pkg::rec_t      new_i,
  input  logic                 occ_i,
  input  logic                 prev_lt_i,
  input  sktbl_pkg::rec_t      left_i,
  input  sktbl_pkg::rec_t      right_i,
  output sktbl_pkg::rec_t      rec_o,
  output logic                 lt_o,
  output logic                 hit_o
);

  sktbl_pkg::rec_t rec_q, rec_d;

  assign lt_o  = occ_i && (rec_q.key < new_i.key);
  assign hit_o = occ_i && (rec_q.key == new_i.key);
  assign rec_o = rec_q;

  // Cells at or past the insert point take the new record or their left neighbor;
  // on delete they take their right neighbor, and on update the hit cell takes the new value.
  always_comb begin
    rec_d = rec_q;
    if (ctl_i.ins && !lt_o) begin
      rec_d = prev_lt_i ? new_i : left_i;
    end
    if (ctl_i.del && !lt_o) begin
      rec_d = right_i;
    end
    if (ctl_i.upd && hit_o) begin
      rec_d.value = new_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

`default_nettype wire

/* hdl/sorted_key_record_table.sv */
// The request is captured into the payload registers at its transfer; its first result
//   is registered into the output register from the execute state once that is free.
// The block takes no new request until the current one is done; a dump gives one
//   record per cycle while the output register is free, and holds the block to its last.
// All compares and the shift of the cell row happen in the same execute-state cycle.
// Reset: clears the record count and the handshake control; record contents are not
//   cleared and need no clearing pass, since entries past the count are never read.
`default_nettype none

module sorted_key_record_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  sktbl_req_if.sink    req_i,
  sktbl_rsp_if.source  rsp_o
);

  localparam int unsigned Cap  = sktbl_pkg::CAPACITY;
  localparam int unsigned CntW = sktbl_pkg::CNT_W;
  localparam int unsigned IdxW = sktbl_pkg::IDX_W;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Result with zeroed fields for every status other than ok.
  function automatic sktbl_pkg::rsp_t fail_rsp(input sktbl_pkg::status_e st);
    sktbl_pkg::rsp_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // Control state.
  state_e          state_q, state_d;
  logic            rdy_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_vld_q, out_vld_d;

  // Payload registers.
  logic [sktbl_pkg::REQ_W-1:0] req_type_q;
  sktbl_pkg::rec_t             new_q;
  sktbl_pkg::rsp_t             rsp_q, rsp_d;

  // Cell row.
  sktbl_pkg::cell_ctl_t ctl;
  sktbl_pkg::rec_t      cell_rec [Cap];
  logic [Cap-1:0]       occ, lt, hit;
  sktbl_pkg::rec_t      hit_rec;
  logic                 any_hit;
  logic                 out_free;
  logic                 dump_last;
  logic                 req_xfer;

  assign req_xfer    = req_i.valid && rdy_q;
  assign req_i.ready = rdy_q;

  // ------------------------------------------------------------------
  // Row of cells: each compares its key against the request key and
  // shifts left or right with its neighbors in the same cycle.
  // ------------------------------------------------------------------
  for (genvar g = 0; g < Cap; g++) begin : g_cell
    sktbl_pkg::rec_t left_rec, right_rec;
    logic            prev_lt;

    assign occ[g] = (CntW'(g) < cnt_q);

    if (g == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign left_rec = '0;
    end else begin : g_mid
      assign prev_lt  = lt[g-1];
      assign left_rec = cell_rec[g-1];
    end

    if (g == Cap - 1) begin : g_end
      assign right_rec = '0;
    end else begin : g_inner
      assign right_rec = cell_rec[g+1];
    end

    sktbl_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .new_i     (new_q),
      .occ_i     (occ[g]),
      .prev_lt_i (prev_lt),
      .left_i    (left_rec),
      .right_i   (right_rec),
      .rec_o     (cell_rec[g]),
      .lt_o      (lt[g]),
      .hit_o     (hit[g])
    );
  end

  // Keys are unique, so at most one cell hits: OR the gated records.
  always_comb begin
    hit_rec = '0;
    for (int i = 0; i < Cap; i++) begin
      hit_rec = hit_rec | (hit[i] ? cell_rec[i] : '0);
    end
  end

  assign any_hit   = |hit;
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign dump_last = ((CntW'(idx_q) + sktbl_pkg::CNT_ONE) == cnt_q);

  // ------------------------------------------------------------------
  // Sequencer: capture a request, then execute it when the output
  // register is free; a dump walks the row one record per cycle while
  // the output register stays free.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    rsp_d     = rsp_q;
    ctl       = '0;

    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (req_xfer) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (req_type_q)
          sktbl_pkg::REQ_INSERT: begin
            if (out_free) begin
              out_vld_d = 1'b1;
              state_d   = ST_IDLE;
              if (any_hit) begin
                rsp_d = fail_rsp(sktbl_pkg::STAT_DUP);
              end else if (cnt_q == sktbl_pkg::CNT_CAP) begin
                rsp_d = fail_rsp(sktbl_pkg::STAT_FULL);
              end else begin
                ctl.ins            = 1'b1;
                cnt_d              = cnt_q + sktbl_pkg::CNT_ONE;
                rsp_d.status       = sktbl_pkg::STAT_OK;
                rsp_d.key          = new_q.key;
                rsp_d.name         = new_q.name;
                rsp_d.value_before = new_q.value;
                rsp_d.value_now    = new_q.value;
                rsp_d.last         = 1'b1;
              end
            end
          end
          sktbl_pkg::REQ_UPDATE: begin
            if (out_free) begin
              out_vld_d = 1'b1;
              state_d   = ST_IDLE;
              if (any_hit) begin
                ctl.upd            = 1'b1;
                rsp_d.status       = sktbl_pkg::STAT_OK;
                rsp_d.key          = hit_rec.key;
                rsp_d.name         = hit_rec.name;
                rsp_d.value_before = hit_rec.value;
                rsp_d.value_now    = new_q.value;
                rsp_d.last         = 1'b1;
              end else begin
                rsp_d = fail_rsp(sktbl_pkg::STAT_NOTFOUND);
              end
            end
          end
          sktbl_pkg::REQ_DELETE, sktbl_pkg::REQ_FIND: begin
            if (out_free) begin
              out_vld_d = 1'b1;
              state_d   = ST_IDLE;
              if (any_hit) begin
                if (req_type_q == sktbl_pkg::REQ_DELETE) begin
                  ctl.del = 1'b1;
                  cnt_d   = cnt_q - sktbl_pkg::CNT_ONE;
                end
                rsp_d.status       = sktbl_pkg::STAT_OK;
                rsp_d.key          = hit_rec.key;
                rsp_d.name         = hit_rec.name;
                rsp_d.value_before = hit_rec.value;
                rsp_d.value_now    = hit_rec.value;
                rsp_d.last         = 1'b1;
              end else begin
                rsp_d = fail_rsp(sktbl_pkg::STAT_NOTFOUND);
              end
            end
          end
          sktbl_pkg::REQ_DUMP: begin
            if (out_free) begin
              out_vld_d = 1'b1;
              if (cnt_q == '0) begin
                rsp_d   = fail_rsp(sktbl_pkg::STAT_NOTFOUND);
                state_d = ST_IDLE;
              end else begin
                rsp_d.status       = sktbl_pkg::STAT_OK;
                rsp_d.key          = cell_rec[idx_q].key;
                rsp_d.name         = cell_rec[idx_q].name;
                rsp_d.value_before = cell_rec[idx_q].value;
                rsp_d.value_now    = cell_rec[idx_q].value;
                rsp_d.last         = dump_last;
                idx_d              = idx_q + sktbl_pkg::IDX_ONE;
                if (dump_last) state_d = ST_IDLE;
              end
            end
          end
          default: begin
            // Unused request codes: drop without a result.
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rdy_q     <= 1'b0;
      cnt_q     <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rdy_q     <= (state_d == ST_IDLE);
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: hold the request, clip the name on capture.
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      req_type_q  <= req_i.req_type;
      new_q.key   <= req_i.key;
      new_q.name  <= sktbl_pkg::clip_name(req_i.name);
      new_q.value <= req_i.salary;
    end
    rsp_q <= rsp_d;
  end

  // Output register drives the result channel.
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.rec_key      = rsp_q.key;
  assign rsp_o.rec_name     = rsp_q.name;
  assign rsp_o.value_before = rsp_q.value_before;
  assign rsp_o.value_now    = rsp_q.value_now;
  assign rsp_o.last         = rsp_q.last;

endmodule

`default_nettype wire

/* hdl/sktbl_checker.sv */
`include "sorted_key_record_table_defines.svh"
`default_nettype none

module sktbl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [sktbl_pkg::STAT_W-1:0] rsp_status_i,
  input logic [sktbl_pkg::KEY_W-1:0]  rsp_rec_key_i,
  input logic [sktbl_pkg::VAL_W-1:0]  rsp_value_before_i,
  input logic [sktbl_pkg::VAL_W-1:0]  rsp_value_now_i,
  input logic                         rsp_last_i
);

  // A transfer on the request side takes the block busy: ready drops right after it.
  `SKT_ASSERT(a_busy_after_req, (req_valid_i && req_ready_i) |=> !req_ready_i)

  // Stalled result holds.
  `SKT_ASSERT(a_rsp_hold, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_rec_key_i) && $stable(rsp_last_i)))

  // Any failure status ends its request and carries zeroed fields.
  `SKT_ASSERT(a_fail_zero, (rsp_valid_i && (rsp_status_i != sktbl_pkg::STAT_OK)) |-> (rsp_last_i && (rsp_rec_key_i == '0) && (rsp_value_before_i == '0) && (rsp_value_now_i == '0)))

  // A dump keeps streaming: after a non-final transfer the next result is already there.
  `SKT_ASSERT(a_dump_stream, (rsp_valid_i && rsp_ready_i && !rsp_last_i) |=> rsp_valid_i)

endmodule

bind sorted_key_record_table sktbl_checker u_sktbl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_rec_key_i      (rsp_o.rec_key),
  .rsp_value_before_i (rsp_o.value_before),
  .rsp_value_now_i    (rsp_o.value_now),
  .rsp_last_i         (rsp_o.last)
);

`default_nettype wire

/* test/sorted_key_record_table_tb.sv */
`default_nettype none

module sorted_key_record_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sktbl_pkg::*;

  // Request codes the block has no use for; it must drop them without a result.
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 1000;
  // Cycles to watch for stray results once nothing more is owed.
  localparam int unsigned TAIL_CYCLES = 24;

  logic clk_i;
  logic rst_ni;

  sktbl_req_if req_ch ();
  sktbl_rsp_if rsp_ch ();

  sorted_key_record_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  // Shadow copy of the table, kept in ascending key order.
  logic [KEY_W-1:0]  shadow_keys   [CAPACITY];
  logic [NAME_W-1:0] shadow_names  [CAPACITY];
  logic [VAL_W-1:0]  shadow_values [CAPACITY];
  int unsigned       shadow_count;

  // Results the block still owes, oldest first.
  rsp_t owed_responses [$];

  int unsigned mismatches;
  // Random bubbles on both channels while set; cleared for the final stretch.
  bit          idle_en;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Mismatch reporting: one line per problem, count every one.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // A stored name holds the bytes up to the first zero byte, at most KEEP_BYTES.
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    kept = '0;
    for (int b = 0; b < KEEP_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'h00) break;
      kept[8*b +: 8] = raw[8*b +: 8];
    end
    return kept;
  endfunction

  function automatic void owe_result(input status_e st, input logic [KEY_W-1:0] k,
                                     input logic [NAME_W-1:0] nm,
                                     input logic [VAL_W-1:0] vb,
                                     input logic [VAL_W-1:0] vn, input logic lst);
    rsp_t r;
    r.status       = st;
    r.key          = k;
    r.name         = nm;
    r.value_before = vb;
    r.value_now    = vn;
    r.last         = lst;
    owed_responses.push_back(r);
  endfunction

  // Apply one transferred request to the shadow table and queue what it owes.
  function automatic void apply_to_shadow_table(input logic [REQ_W-1:0] op,
                                                input logic [KEY_W-1:0] k,
                                                input logic [NAME_W-1:0] nm,
                                                input logic [VAL_W-1:0] sal);
    int unsigned       pos;
    bit                hit;
    logic [VAL_W-1:0]  prior;
    // First slot whose key is not below k.
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < k) pos++;
    hit = (pos < shadow_count) && (shadow_keys[pos] == k);

    case (op)
      REQ_INSERT: begin
        // Duplicate wins over full.
        if (hit) begin
          owe_result(STAT_DUP, '0, '0, '0, '0, 1'b1);
        end else if (shadow_count >= CAPACITY) begin
          owe_result(STAT_FULL, '0, '0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = shadow_count; i > pos; i--) begin
            shadow_keys[i]   = shadow_keys[i-1];
            shadow_names[i]  = shadow_names[i-1];
            shadow_values[i] = shadow_values[i-1];
          end
          shadow_keys[pos]   = k;
          shadow_names[pos]  = trim_name(nm);
          shadow_values[pos] = sal;
          shadow_count++;
          owe_result(STAT_OK, k, shadow_names[pos], sal, sal, 1'b1);
        end
      end
      REQ_UPDATE: begin
        if (!hit) begin
          owe_result(STAT_NOTFOUND, '0, '0, '0, '0, 1'b1);
        end else begin
          prior              = shadow_values[pos];
          shadow_values[pos] = sal;
          owe_result(STAT_OK, k, shadow_names[pos], prior, sal, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (!hit) begin
          owe_result(STAT_NOTFOUND, '0, '0, '0, '0, 1'b1);
        end else begin
          owe_result(STAT_OK, shadow_keys[pos], shadow_names[pos], shadow_values[pos],
                     shadow_values[pos], 1'b1);
          for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i]   = shadow_keys[i+1];
            shadow_names[i]  = shadow_names[i+1];
            shadow_values[i] = shadow_values[i+1];
          end
          shadow_count--;
        end
      end
      REQ_FIND: begin
        if (!hit)
          owe_result(STAT_NOTFOUND, '0, '0, '0, '0, 1'b1);
        else
          owe_result(STAT_OK, shadow_keys[pos], shadow_names[pos], shadow_values[pos],
                     shadow_values[pos], 1'b1);
      end
      REQ_DUMP: begin
        // An empty table still answers, with a single not-found.
        if (shadow_count == 0) begin
          owe_result(STAT_NOTFOUND, '0, '0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < shadow_count; i++)
            owe_result(STAT_OK, shadow_keys[i], shadow_names[i], shadow_values[i],
                       shadow_values[i], (i + 1 == shadow_count));
        end
      end
      default: begin
        // Spare codes: no result, no change.
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Present one request and hold it until the transfer. Valid is only lowered
  // when a bubble is inserted, so back-to-back requests keep it high.
  task automatic send_request(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [NAME_W-1:0] nm, input logic [VAL_W-1:0] sal);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key      <= k;
    req_ch.name     <= nm;
    req_ch.salary   <= sal;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    apply_to_shadow_table(op, k, nm, sal);
  endtask

  function automatic logic [NAME_W-1:0] random_name();
    logic [NAME_W-1:0] nm;
    nm = NAME_W'({$urandom(), $urandom()});
    // Now and then cut the name short with a zero byte somewhere inside.
    if ($urandom_range(0, 3) == 0) nm[8*$urandom_range(0, 6) +: 8] = 8'h00;
    return nm;
  endfunction

  // Half the time a key already in the table, else a narrow pool that collides often,
  // the extremes, or anything at all.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (shadow_count != 0 && sel < 5)
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    if (sel < 8)
      return KEY_W'($urandom_range(0, 40));
    if (sel == 8) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return '1;
        default: return {1'b1, {(KEY_W-1){1'b0}}};
      endcase
    end
    return $urandom();
  endfunction

  function automatic bit key_present(input logic [KEY_W-1:0] k);
    for (int unsigned i = 0; i < shadow_count; i++)
      if (shadow_keys[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls on ready, and the check of every transfer.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!idle_en) begin
        stall_left = 0;
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        // Start a burst of stalls on ready, this cycle included.
        stall_left = $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_result();
    rsp_t want;
    if (owed_responses.size() == 0) begin
      report_mismatch("result with nothing outstanding, key", rsp_ch.rec_key, '0);
    end else begin
      want = owed_responses.pop_front();
      if (rsp_ch.status !== want.status)
        report_mismatch("status", rsp_ch.status, want.status);
      if (rsp_ch.rec_key !== want.key)
        report_mismatch("rec_key", rsp_ch.rec_key, want.key);
      if (rsp_ch.rec_name !== want.name)
        report_mismatch("rec_name", rsp_ch.rec_name, want.name);
      if (rsp_ch.value_before !== want.value_before)
        report_mismatch("value_before", rsp_ch.value_before, want.value_before);
      if (rsp_ch.value_now !== want.value_now)
        report_mismatch("value_now", rsp_ch.value_now, want.value_now);
      if (rsp_ch.last !== want.last)
        report_mismatch("last", rsp_ch.last, want.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) check_result();
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("sorted_key_record_table_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Dump, find, update and delete against an empty table, the empty dump included.
  task automatic test_empty_table();
    send_request(REQ_DUMP, '0, random_name(), $urandom());
    send_request(REQ_FIND, '1, random_name(), $urandom());
    send_request(REQ_UPDATE, '0, random_name(), '1);
    send_request(REQ_DELETE, 32'h0000_1234, random_name(), $urandom());
  endtask

  // Key, value and name extremes, name clipping, and a duplicate.
  task automatic test_insert_edges();
    // All name bits high: only the kept bytes survive.
    send_request(REQ_INSERT, 32'h8000_0000, '1, '0);
    // Empty name.
    send_request(REQ_INSERT, '0, '0, '1);
    // Zero byte in the third position ends the name there.
    send_request(REQ_INSERT, '1, 56'h00_0000_4400_4241, 32'h5555_5555);
    // Full-length name with no zero byte.
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 56'h01_0203_0405_0607, 32'hAAAA_AAAA);
    send_request(REQ_INSERT, '0, random_name(), $urandom());
    send_request(REQ_DUMP, $urandom(), random_name(), $urandom());
  endtask

  // Update, find and delete at the head, tail and middle of the table.
  task automatic test_modify_edges();
    send_request(REQ_UPDATE, '1, random_name(), '0);
    send_request(REQ_UPDATE, '0, random_name(), '1);
    send_request(REQ_FIND, 32'h8000_0000, random_name(), $urandom());
    send_request(REQ_DELETE, '0, random_name(), $urandom());
    send_request(REQ_DELETE, '1, random_name(), $urandom());
    send_request(REQ_DELETE, 32'h7FFF_FFFF, random_name(), $urandom());
    send_request(REQ_FIND, '0, random_name(), $urandom());
    send_request(REQ_DUMP, $urandom(), random_name(), $urandom());
  endtask

  // Spare codes must be dropped; follow with a find to see the table intact.
  task automatic test_spare_codes();
    for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++)
      send_request(REQ_W'(c), 32'h8000_0000, random_name(), $urandom());
    send_request(REQ_FIND, 32'h8000_0000, random_name(), $urandom());
  endtask

  // Fill to capacity, then hit the full and the duplicate-on-full cases.
  task automatic test_fill_to_capacity();
    logic [KEY_W-1:0] fresh;
    while (shadow_count < CAPACITY)
      send_request(REQ_INSERT, pick_key(), random_name(), $urandom());
    do fresh = $urandom(); while (key_present(fresh));
    send_request(REQ_INSERT, fresh, random_name(), $urandom());
    send_request(REQ_INSERT, shadow_keys[$urandom_range(0, CAPACITY - 1)],
                 random_name(), $urandom());
    send_request(REQ_UPDATE, shadow_keys[CAPACITY - 1], random_name(), $urandom());
    send_request(REQ_DUMP, $urandom(), random_name(), $urandom());
    // Thin the table back out.
    repeat (CAPACITY / 2)
      send_request(REQ_DELETE, shadow_keys[$urandom_range(0, shadow_count - 1)],
                   random_name(), $urandom());
  endtask

  // Weighted random mix; inserts ease off once the table is well filled.
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned      roll;
    int unsigned      ins_top;
    logic [REQ_W-1:0] op;
    repeat (n_items) begin
      roll    = $urandom_range(0, 99);
      ins_top = (shadow_count < 12) ? 45 : 30;
      if (roll < 3)            op = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      else if (roll < 8)       op = REQ_DUMP;
      else if (roll < ins_top) op = REQ_INSERT;
      else if (roll < 62)      op = REQ_DELETE;
      else if (roll < 80)      op = REQ_UPDATE;
      else                     op = REQ_FIND;
      send_request(op, pick_key(), random_name(), $urandom());
    end
  endtask

  // Delete everything that is left, with finds in between, and dump the empty table.
  task automatic test_drain_table();
    while (shadow_count > 0) begin
      if ($urandom_range(0, 2) == 0)
        send_request(REQ_FIND, pick_key(), random_name(), $urandom());
      send_request(REQ_DELETE, shadow_keys[$urandom_range(0, shadow_count - 1)],
                   random_name(), $urandom());
    end
    send_request(REQ_DUMP, $urandom(), random_name(), $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches   = 0;
    shadow_count = 0;
    idle_en      = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_keys[i]   = '0;
      shadow_names[i]  = '0;
      shadow_values[i] = '0;
    end
    rst_ni          <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_FIND;
    req_ch.key      <= '0;
    req_ch.name     <= '0;
    req_ch.salary   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_insert_edges();
    test_modify_edges();
    test_spare_codes();
    test_fill_to_capacity();
    test_random_mix(80);
    test_drain_table();

    // Final stretch at full rate on both sides.
    idle_en = 1'b0;
    test_fill_to_capacity();
    test_random_mix(40);

    // Drop valid after the last transfer, let the owed results arrive, then
    // watch a while longer for anything extra.
    req_ch.valid <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("sorted_key_record_table_tb OK");
    else
      $display("sorted_key_record_table_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
